// ----- rtl/core/hst_pkg.sv -----
`timescale 1ns / 1ps
package hst_pkg;

  // Field widths
  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int SPEED_W      = 16;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int ZW           = 32;                      // 2^32 = 360 deg
  localparam int PRE_SHIFT    = 58 - COORD_WIDTH;
  localparam int DIFF_W       = COORD_WIDTH + 1;         // goal - robot, exact
  localparam int XY_W         = DIFF_W + PRE_SHIFT + 3;  // headroom for CORDIC gain

  localparam logic [ZW-1:0] Z_HALF_TURN = ZW'(1) << (ZW - 1);
  localparam logic [ZW-1:0] BRG_ROUND   = ZW'(1) << (ZW - 1 - ANGLE_WIDTH);

  localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // Steering constants
  localparam logic [SPEED_W-1:0] HALF_SPEED = SPEED_W'(1) << (SPEED_W - 2);
  localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN =
    ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
  localparam logic signed [ANGLE_WIDTH-1:0] NEG_QUARTER_TURN = -QUARTER_TURN;

  // Word from the difference stage into the CORDIC
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     flip;
    logic                     zero;
    logic [ANGLE_WIDTH-1:0]   hd;
  } prep_word_t;

  // Word from the CORDIC into the steering stages
  typedef struct packed {
    logic [ZW-1:0]          z;
    logic [ANGLE_WIDTH-1:0] hd;
  } bearing_word_t;

endpackage

// ----- rtl/core/hst_prep.sv -----
`timescale 1ns / 1ps
module hst_prep (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0]     robot_x,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0]     robot_y,
  input  logic signed [hst_pkg::ANGLE_WIDTH-1:0]     heading,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0]     goal_x,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0]     goal_y,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output hst_pkg::prep_word_t                        out_word
);
  import hst_pkg::*;

  logic                     valid;
  logic                     load;
  prep_word_t               word;
  prep_word_t               word_next;
  logic signed [DIFF_W-1:0] dx_raw;
  logic signed [DIFF_W-1:0] dy_raw;

  assign load     = ~valid | out_ready;
  assign in_ready = load & ~rst;

  // Fold the left half plane onto the right by a half turn.
  always_comb begin
    dx_raw         = DIFF_W'(goal_x) - DIFF_W'(robot_x);
    dy_raw         = DIFF_W'(goal_y) - DIFF_W'(robot_y);
    word_next.flip = dx_raw[DIFF_W-1];
    word_next.dx   = word_next.flip ? -dx_raw : dx_raw;
    word_next.dy   = word_next.flip ? -dy_raw : dy_raw;
    word_next.zero = (dx_raw == '0) && (dy_raw == '0);
    word_next.hd   = heading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

// ----- rtl/core/hst_cordic.sv -----
`timescale 1ns / 1ps
module hst_cordic (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hst_pkg::prep_word_t    in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hst_pkg::bearing_word_t out_word
);
  import hst_pkg::*;

  localparam int LAST = CORDIC_STEPS - 1;

  logic signed [XY_W-1:0]  x_in    [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_in    [CORDIC_STEPS];
  logic [ZW-1:0]           z_in    [CORDIC_STEPS];
  logic [ANGLE_WIDTH-1:0]  hd_in   [CORDIC_STEPS];
  logic                    zero_in [CORDIC_STEPS];
  logic                    v_in    [CORDIC_STEPS];

  logic signed [XY_W-1:0]  x_r     [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_r     [CORDIC_STEPS];
  logic [ZW-1:0]           z_r     [CORDIC_STEPS];
  logic [ANGLE_WIDTH-1:0]  hd_r    [CORDIC_STEPS];
  logic                    zero_r  [CORDIC_STEPS];
  logic                    v_r     [CORDIC_STEPS];
  logic                    load    [CORDIC_STEPS];

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [XY_W-1:0] xsh;
      logic signed [XY_W-1:0] ysh;
      logic signed [XY_W-1:0] x_next;
      logic signed [XY_W-1:0] y_next;
      logic [ZW-1:0]          z_next;
      logic                   y_pos;

      if (i == 0) begin : g_head
        assign x_in[i]    = XY_W'(in_word.dx) <<< PRE_SHIFT;
        assign y_in[i]    = XY_W'(in_word.dy) <<< PRE_SHIFT;
        assign z_in[i]    = in_word.flip ? Z_HALF_TURN : '0;
        assign hd_in[i]   = in_word.hd;
        assign zero_in[i] = in_word.zero;
        assign v_in[i]    = in_valid;
      end else begin : g_link
        assign x_in[i]    = x_r[i-1];
        assign y_in[i]    = y_r[i-1];
        assign z_in[i]    = z_r[i-1];
        assign hd_in[i]   = hd_r[i-1];
        assign zero_in[i] = zero_r[i-1];
        assign v_in[i]    = v_r[i-1];
      end

      if (i == LAST) begin : g_tail
        assign load[i] = ~v_r[i] | out_ready;
      end else begin : g_mid
        assign load[i] = ~v_r[i] | load[i+1];
      end

      // One micro-rotation: drive y toward zero, track the angle.
      always_comb begin
        xsh   = x_in[i] >>> i;
        ysh   = y_in[i] >>> i;
        y_pos = ~y_in[i][XY_W-1] && (y_in[i] != '0);
        if (y_pos) begin
          x_next = x_in[i] + ysh;
          y_next = y_in[i] - xsh;
          z_next = z_in[i] + ATAN_TAB[i];
        end else begin
          x_next = x_in[i] - ysh;
          y_next = y_in[i] + xsh;
          z_next = z_in[i] - ATAN_TAB[i];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v_r[i] <= 1'b0;
        end else if (load[i]) begin
          v_r[i] <= v_in[i];
        end
      end

      always_ff @(posedge clk) begin
        if (load[i] && v_in[i]) begin
          x_r[i]    <= x_next;
          y_r[i]    <= y_next;
          z_r[i]    <= z_next;
          hd_r[i]   <= hd_in[i];
          zero_r[i] <= zero_in[i];
        end
      end
    end
  endgenerate

  assign in_ready    = load[0];
  assign out_valid   = v_r[LAST];
  // Target on robot: bearing is zero.
  assign out_word.z  = zero_r[LAST] ? '0 : z_r[LAST];
  assign out_word.hd = hd_r[LAST];

endmodule

// ----- rtl/core/hst_steer.sv -----
`timescale 1ns / 1ps
module hst_steer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hst_pkg::bearing_word_t         in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hst_pkg::SPEED_W-1:0]    left_speed,
  output logic [hst_pkg::SPEED_W-1:0]    right_speed
);
  import hst_pkg::*;

  localparam int DW = SPEED_W + 1;

  logic                          valid_a;
  logic                          valid_b;
  logic                          load_a;
  logic                          load_b;
  logic [ZW-1:0]                 z_round;
  logic signed [ANGLE_WIDTH-1:0] err_next;
  logic signed [ANGLE_WIDTH-1:0] err_a;
  logic signed [DW-1:0]          d;
  logic [SPEED_W-1:0]            left_next;
  logic [SPEED_W-1:0]            right_next;
  logic [SPEED_W-1:0]            left_b;
  logic [SPEED_W-1:0]            right_b;

  assign load_b   = ~valid_b | out_ready;
  assign load_a   = ~valid_a | load_b;
  assign in_ready = load_a;

  // Round bearing to the angle width, then take the wrapped error.
  always_comb begin
    z_round  = in_word.z + BRG_ROUND;
    err_next = z_round[ZW-1 -: ANGLE_WIDTH] - in_word.hd;
  end

  // Scale error to speed units (err/180 with 1.0 at half the speed range).
  generate
    if (ANGLE_WIDTH <= SPEED_W) begin : g_widen
      assign d = DW'(err_a) <<< (SPEED_W - ANGLE_WIDTH);
    end else begin : g_narrow
      logic signed [ANGLE_WIDTH:0] err_rnd;
      assign err_rnd = (ANGLE_WIDTH + 1)'(err_a)
                     + ((ANGLE_WIDTH + 1)'(1) << (ANGLE_WIDTH - SPEED_W - 1));
      assign d = DW'(err_rnd >>> (ANGLE_WIDTH - SPEED_W));
    end
  endgenerate

  always_comb begin
    if (err_a >= QUARTER_TURN) begin
      left_next  = '0;
      right_next = HALF_SPEED;
    end else if (err_a <= NEG_QUARTER_TURN) begin
      left_next  = HALF_SPEED;
      right_next = '0;
    end else begin
      left_next  = SPEED_W'(DW'(HALF_SPEED) - d);
      right_next = SPEED_W'(DW'(HALF_SPEED) + d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (load_a) begin
        valid_a <= in_valid;
      end
      if (load_b) begin
        valid_b <= valid_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a && in_valid) begin
      err_a <= err_next;
    end
    if (load_b && valid_a) begin
      left_b  <= left_next;
      right_b <= right_next;
    end
  end

  assign out_valid   = valid_b;
  assign left_speed  = left_b;
  assign right_speed = right_b;

endmodule

// ----- rtl/core/heading_steering_to_target.sv -----
`timescale 1ns / 1ps
// Pipeline: 1 difference stage, 30 CORDIC micro-rotation stages and 2
//   steering stages between pose accepted and wheel word valid.
// Throughput: one pose per cycle while out_ready is high; each stage holds
//   one word, so the pipe fills its bubbles while a finished word waits.
// Reset: synchronous, active high; clears every stage valid bit, in_ready low.
module heading_steering_to_target (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0] robot_x,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0] robot_y,
  input  logic signed [hst_pkg::ANGLE_WIDTH-1:0] heading,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0] goal_x,
  input  logic signed [hst_pkg::COORD_WIDTH-1:0] goal_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [hst_pkg::SPEED_W-1:0]            left_speed,
  output logic [hst_pkg::SPEED_W-1:0]            right_speed
);
  import hst_pkg::*;

  // Difference stage -> CORDIC
  logic          prep_valid;
  logic          prep_ready;
  prep_word_t    prep_word;

  // CORDIC -> steering
  logic          brg_valid;
  logic          brg_ready;
  bearing_word_t brg_word;

  // Stage 1: goal minus robot, fold the left half plane by a half turn
  // so the CORDIC only sees x >= 0, and flag the target-on-robot case.
  hst_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .robot_x   (robot_x),
    .robot_y   (robot_y),
    .heading   (heading),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_word  (prep_word)
  );

  // Stages 2..31: vectoring CORDIC, one micro-rotation per stage. The angle
  // accumulator runs modulo a full turn in 32 bits; the heading rides along.
  hst_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_word   (prep_word),
    .out_valid (brg_valid),
    .out_ready (brg_ready),
    .out_word  (brg_word)
  );

  // Stages 32..33: round the bearing, wrap the heading error, then choose
  // a pivot on one wheel or proportional wheel speeds around half speed.
  hst_steer u_steer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (brg_valid),
    .in_ready    (brg_ready),
    .in_word     (brg_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_speed  (left_speed),
    .right_speed (right_speed)
  );

endmodule

// ----- rtl/core/hst_checker.sv -----
`timescale 1ns / 1ps
module hst_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hst_pkg::SPEED_W-1:0] left_speed,
  input logic [hst_pkg::SPEED_W-1:0] right_speed
);
  import hst_pkg::*;

  logic [SPEED_W:0] speed_sum;
  assign speed_sum = {1'b0, left_speed} + {1'b0, right_speed};

  // Hold a stalled word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(left_speed) && $stable(right_speed))
    else $error("wheel word changed while stalled");

  // Either spin at half speed on one wheel, or the two speeds sum to 1.0.
  a_speed_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_sum == (SPEED_W + 1)'(2 * HALF_SPEED))
               || (left_speed == '0 && right_speed == HALF_SPEED)
               || (left_speed == HALF_SPEED && right_speed == '0))
    else $error("wheel speeds inconsistent");

  // Drop everything in flight on reset; refuse input while reset is high.
  a_reset_empty: assert property (@(posedge clk)
    rst |-> !in_ready ##1 !out_valid)
    else $error("pipe not empty after reset");

endmodule

bind heading_steering_to_target hst_checker u_hst_checker (.*);
